@@ src/fat_table_entry_engine_assert.svh @@
// ----------------------------------------------------------------------------
// fat_table_entry_engine_assert.svh
// Assertion macros used by the FAT table entry engine controller.
// ----------------------------------------------------------------------------
`ifndef FAT_TABLE_ENTRY_ENGINE_ASSERT_SVH
`define FAT_TABLE_ENTRY_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk, disabled while rst_n is low.
`define FTE_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, disabled while rst_n is low.
`define FTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fte_pkg.sv @@
// ----------------------------------------------------------------------------
// fte_pkg
// Types, codes and constants shared by the FAT table entry engine.
// ----------------------------------------------------------------------------
package fte_pkg;

    localparam int FTE_TABLE_SIZE_DEFAULT = 65536;

    localparam int CLUSTER_W   = 28;
    localparam int ENTRY_W     = 28;
    localparam int STATUS_W    = 3;
    localparam int MODE_W      = 2;
    localparam int CFG_DATA_W  = 28;
    localparam int CFG_INDEX_W = 1;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 32;

    localparam logic [MODE_W-1:0]    MODE_RESET        = 2'd1;
    localparam logic [CLUSTER_W-1:0] MAX_CLUSTER_RESET = 28'd2;

    localparam logic [ENTRY_W-1:0] EOC_FAT12 = 28'h0000FF8;
    localparam logic [ENTRY_W-1:0] EOC_FAT16 = 28'h000FFF8;
    localparam logic [ENTRY_W-1:0] EOC_FAT32 = 28'hFFFFFF8;

    typedef enum logic [1:0] {
        PK_FAT12 = 2'd0,
        PK_FAT16 = 2'd1,
        PK_FAT32 = 2'd2
    } pack_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEXT  = 3'd0,
        ST_EOC   = 3'd1,
        ST_BAD   = 3'd2,
        ST_WROTE = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FAT_WIDTH_MODE = 1'b0,
        CFG_MAX_CLUSTER    = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_CLEAR   = 4'd0,
        S_IDLE    = 4'd1,
        S_CHECK   = 4'd2,
        S_READ    = 4'd3,
        S_RDWAIT  = 4'd4,
        S_PREREAD = 4'd5,
        S_PREWAIT = 4'd6,
        S_WRITE   = 4'd7,
        S_FINISH  = 4'd8
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_step;  // write zero at the clear pointer, advance it
        logic load;        // capture the accepted item, rewind the byte index
        logic check;       // latch byte offset and range verdict
        logic rd_issue;    // read one table byte
        logic use_pre;     // read the byte kept by a merge write
        logic mem_we;      // write one byte of the merged entry
        logic idx_inc;     // advance the byte index
        logic out_load;    // load the result register
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic  clear_last;  // clear pointer on the last byte
        logic  range_chk;   // item out of range (valid in S_CHECK)
        logic  range_hit;   // latched out-of-range verdict
        logic  is_write;    // current item is a write
        pack_t pack;        // decoded entry packing
        logic  idx_last;    // byte index on the last byte of the entry
        logic  out_full;    // result register holds an item not taken
    } stat_t;

endpackage

@@ src/fte_datapath.sv @@
// ----------------------------------------------------------------------------
// fte_datapath
// Configuration registers, table byte memory, offset and range check,
// entry merge on writes and entry unpack and classify on reads.
// ----------------------------------------------------------------------------
module fte_datapath #(
    parameter int TABLE_SIZE_BYTES = fte_pkg::FTE_TABLE_SIZE_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fte_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fte_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [fte_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fte_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [fte_pkg::STATUS_W-1:0]     m_tuser,
    input  fte_pkg::cmd_t                    cmd,
    output fte_pkg::stat_t                   stat
);

    localparam int AW = (TABLE_SIZE_BYTES > 1) ? $clog2(TABLE_SIZE_BYTES) : 1;
    localparam logic [31:0]   SIZE32    = 32'(TABLE_SIZE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE_BYTES - 1);

    logic [fte_pkg::MODE_W-1:0]    mode_reg;
    logic [fte_pkg::CLUSTER_W-1:0] max_reg;

    logic                          write_reg;
    logic [fte_pkg::CLUSTER_W-1:0] cl_reg;
    logic [fte_pkg::ENTRY_W-1:0]   wv_reg;
    logic [AW-1:0]                 off_reg;
    logic                          range_reg;
    logic [1:0]                    idx_reg;
    logic [1:0]                    cap_idx_reg;
    logic                          rd_valid_reg;
    logic [7:0]                    rd_data_reg;
    logic [3:0][7:0]               bytes_reg;
    logic [AW-1:0]                 clr_reg;

    logic                          out_valid_reg;
    logic [fte_pkg::ENTRY_W-1:0]   out_value_reg;
    fte_pkg::status_t              out_status_reg;

    logic [7:0] mem [TABLE_SIZE_BYTES];

    fte_pkg::pack_t              pack;
    logic [31:0]                 cl32;
    logic [31:0]                 off32;
    logic [31:0]                 nb32;
    logic                        range_chk;
    logic                        idx_last;
    logic [1:0]                  pre_idx;
    logic [1:0]                  rd_idx;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic                        mem_wr;
    logic [7:0]                  wr_byte;
    logic [31:0]                 wword;
    logic [fte_pkg::ENTRY_W-1:0] val;
    logic [fte_pkg::ENTRY_W-1:0] eoc;
    fte_pkg::status_t            rd_status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fte_pkg::MODE_RESET;
            max_reg  <= fte_pkg::MAX_CLUSTER_RESET;
        end
        else if (cfg_we)
        begin
            case (fte_pkg::cfg_index_t'(cfg_index))
                fte_pkg::CFG_FAT_WIDTH_MODE: mode_reg <= cfg_data[fte_pkg::MODE_W-1:0];
                fte_pkg::CFG_MAX_CLUSTER:    max_reg  <= cfg_data;
                default:                     mode_reg <= mode_reg;
            endcase
        end
    end

    // High mode bit selects 32-bit packing, so the unused code acts as FAT32.
    always_comb
    begin
        if (mode_reg[1])
            pack = fte_pkg::PK_FAT32;
        else if (mode_reg[0])
            pack = fte_pkg::PK_FAT16;
        else
            pack = fte_pkg::PK_FAT12;
    end

    // Byte offset and range check from the captured item.
    always_comb
    begin
        cl32 = {4'b0, cl_reg};
        case (pack)
            fte_pkg::PK_FAT12:
            begin
                off32 = (cl32 + {cl32[30:0], 1'b0}) >> 1;
                nb32  = 32'd2;
            end
            fte_pkg::PK_FAT16:
            begin
                off32 = {cl32[30:0], 1'b0};
                nb32  = 32'd2;
            end
            default:
            begin
                off32 = {cl32[29:0], 2'b00};
                nb32  = 32'd4;
            end
        endcase
        range_chk = (cl_reg < 28'd2) || (cl_reg > max_reg) || ((off32 + nb32) > SIZE32);
    end

    always_comb
    begin
        case (pack)
            fte_pkg::PK_FAT12:
            begin
                idx_last = (idx_reg == 2'd1);
                pre_idx  = cl_reg[0] ? 2'd0 : 2'd1;
            end
            fte_pkg::PK_FAT16:
            begin
                idx_last = (idx_reg == 2'd1);
                pre_idx  = 2'd0;
            end
            default:
            begin
                idx_last = (idx_reg == 2'd3);
                pre_idx  = 2'd3;
            end
        endcase
    end

    // Merged entry for writes; the kept nibble comes from the pre-read byte.
    always_comb
    begin
        case (pack)
            fte_pkg::PK_FAT12:
            begin
                if (cl_reg[0])
                    wword = {16'b0, wv_reg[11:4], wv_reg[3:0], bytes_reg[0][3:0]};
                else
                    wword = {16'b0, bytes_reg[1][7:4], wv_reg[11:8], wv_reg[7:0]};
            end
            fte_pkg::PK_FAT16:
                wword = {16'b0, wv_reg[15:0]};
            default:
                wword = {bytes_reg[3][7:4], wv_reg};
        endcase
    end

    assign rd_idx  = cmd.use_pre ? pre_idx : idx_reg;
    assign rd_addr = off_reg + AW'(rd_idx);
    assign wr_addr = cmd.clear_step ? clr_reg : (off_reg + AW'(idx_reg));
    assign mem_wr  = cmd.clear_step || cmd.mem_we;
    assign wr_byte = cmd.clear_step ? 8'h00 : wword[{idx_reg, 3'b000} +: 8];

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[wr_addr] <= wr_byte;
        if (cmd.rd_issue)
            rd_data_reg <= mem[rd_addr];
    end

    // Item payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            write_reg <= s_tuser;
            cl_reg    <= s_tdata[27:0];
            wv_reg    <= s_tdata[55:28];
        end
        if (cmd.check)
            off_reg <= off32[AW-1:0];
        if (rd_valid_reg)
            bytes_reg[cap_idx_reg] <= rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg    <= 1'b0;
            idx_reg      <= 2'd0;
            cap_idx_reg  <= 2'd0;
            rd_valid_reg <= 1'b0;
            clr_reg      <= '0;
        end
        else
        begin
            if (cmd.check)
                range_reg <= range_chk;
            if (cmd.load)
                idx_reg <= 2'd0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 2'd1;
            rd_valid_reg <= cmd.rd_issue;
            if (cmd.rd_issue)
                cap_idx_reg <= rd_idx;
            if (cmd.clear_step)
                clr_reg <= clr_reg + AW'(1);
        end
    end

    // Unpack and classify the entry read.
    always_comb
    begin
        case (pack)
            fte_pkg::PK_FAT12:
            begin
                val = cl_reg[0] ? {16'b0, bytes_reg[1], bytes_reg[0][7:4]}
                                : {16'b0, bytes_reg[1][3:0], bytes_reg[0]};
                eoc = fte_pkg::EOC_FAT12;
            end
            fte_pkg::PK_FAT16:
            begin
                val = {12'b0, bytes_reg[1], bytes_reg[0]};
                eoc = fte_pkg::EOC_FAT16;
            end
            default:
            begin
                val = {bytes_reg[3][3:0], bytes_reg[2], bytes_reg[1], bytes_reg[0]};
                eoc = fte_pkg::EOC_FAT32;
            end
        endcase
        if (val >= eoc)
            rd_status = fte_pkg::ST_EOC;
        else if ((val > max_reg) || (val == 28'd1))
            rd_status = fte_pkg::ST_BAD;
        else
            rd_status = fte_pkg::ST_NEXT;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (range_reg)
            begin
                out_value_reg  <= '0;
                out_status_reg <= fte_pkg::ST_RANGE;
            end
            else if (write_reg)
            begin
                out_value_reg  <= '0;
                out_status_reg <= fte_pkg::ST_WROTE;
            end
            else
            begin
                out_value_reg  <= val;
                out_status_reg <= rd_status;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_value_reg};
    assign m_tuser  = out_status_reg;

    always_comb
    begin
        stat.clear_last = (clr_reg == LAST_ADDR);
        stat.range_chk  = range_chk;
        stat.range_hit  = range_reg;
        stat.is_write   = write_reg;
        stat.pack       = pack;
        stat.idx_last   = idx_last;
        stat.out_full   = out_valid_reg && !m_tready;
    end

endmodule

@@ src/fte_ctrl.sv @@
// ----------------------------------------------------------------------------
// fte_ctrl
// Sequencer for the table clearing pass and the byte steps of each access.
// ----------------------------------------------------------------------------
`include "fat_table_entry_engine_assert.svh"

module fte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output fte_pkg::cmd_t  cmd,
    input  fte_pkg::stat_t stat
);

    fte_pkg::state_t state_reg;
    fte_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fte_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fte_pkg::S_CLEAR:
                if (stat.clear_last)
                    state_next = fte_pkg::S_IDLE;
            fte_pkg::S_IDLE:
                if (s_tvalid)
                    state_next = fte_pkg::S_CHECK;
            fte_pkg::S_CHECK:
            begin
                if (stat.range_chk)
                    state_next = fte_pkg::S_FINISH;
                else if (!stat.is_write)
                    state_next = fte_pkg::S_READ;
                else if (stat.pack == fte_pkg::PK_FAT16)
                    state_next = fte_pkg::S_WRITE;
                else
                    state_next = fte_pkg::S_PREREAD;
            end
            fte_pkg::S_READ:
                if (stat.idx_last)
                    state_next = fte_pkg::S_RDWAIT;
            fte_pkg::S_RDWAIT:
                state_next = fte_pkg::S_FINISH;
            fte_pkg::S_PREREAD:
                state_next = fte_pkg::S_PREWAIT;
            fte_pkg::S_PREWAIT:
                state_next = fte_pkg::S_WRITE;
            fte_pkg::S_WRITE:
                if (stat.idx_last)
                    state_next = fte_pkg::S_FINISH;
            fte_pkg::S_FINISH:
                if (!stat.out_full)
                    state_next = fte_pkg::S_IDLE;
            default:
                state_next = fte_pkg::S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            fte_pkg::S_CLEAR:
                cmd.clear_step = 1'b1;
            fte_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            fte_pkg::S_CHECK:
                cmd.check = 1'b1;
            fte_pkg::S_READ:
            begin
                cmd.rd_issue = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            fte_pkg::S_PREREAD:
            begin
                cmd.rd_issue = 1'b1;
                cmd.use_pre  = 1'b1;
            end
            fte_pkg::S_WRITE:
            begin
                cmd.mem_we  = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            fte_pkg::S_FINISH:
                cmd.out_load = !stat.out_full;
            default:
                cmd = '0;
        endcase
    end

    `FTE_ASSERT_HOLDS(a_out_load_free, cmd.out_load, !stat.out_full, "result overwritten")
    `FTE_ASSERT_HOLDS(a_write_in_range, cmd.mem_we, !stat.range_hit, "write out of range")
    `FTE_ASSERT_NEXT(a_read_then_wait, cmd.rd_issue, !cmd.mem_we, "write after read issue")

endmodule

@@ src/fat_table_entry_engine.sv @@
// ----------------------------------------------------------------------------
// fat_table_entry_engine
// FAT12/FAT16/FAT32 allocation table entry read and write engine.
// ----------------------------------------------------------------------------
// The engine keeps a FAT allocation table of TABLE_SIZE_BYTES bytes in one
// byte-wide memory with a single access per cycle, and every item reads or
// writes one cluster's entry in it. After reset the engine runs a clearing
// pass over every table byte (every cluster free) with s_tready low;
// configuration writes are taken during that pass. An item is checked for
// range first and then reads or writes its entry one table byte at a time;
// an out-of-range item touches no byte, and FAT12 and FAT32 writes first
// read the byte that holds the kept nibble. The result sits in an output
// register, so the next item is taken while it waits; an item only stalls
// at its end if the previous result has still not been taken. Write
// fat_width_mode and max_cluster only while no item is in flight.
// ----------------------------------------------------------------------------
module fat_table_entry_engine #(
    parameter int TABLE_SIZE_BYTES = fte_pkg::FTE_TABLE_SIZE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port: index 0 fat_width_mode, 1 max_cluster.
    input  logic                            cfg_we,
    input  logic [fte_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fte_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fte_pkg::IN_DATA_W-1:0]   s_tdata,   // [27:0] cluster, [55:28] write_value
    input  logic                            s_tuser,   // [0] command (0 read, 1 write)
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fte_pkg::OUT_DATA_W-1:0]  m_tdata,   // [27:0] entry_value, [31:28] zero
    output logic [fte_pkg::STATUS_W-1:0]    m_tuser    // [2:0] status
);

    fte_pkg::cmd_t  cmd;
    fte_pkg::stat_t stat;

    // Sequence the clearing pass and the byte steps of each item.
    fte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Hold the table, the registers, the merge and classify logic.
    fte_datapath #(
        .TABLE_SIZE_BYTES (TABLE_SIZE_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for fat_table_entry_engine.
// ----------------------------------------------------------------------------
// Keeps its own image of the allocation table and of both configuration
// registers, predicts the entry value and status of every accepted item, and
// compares each result item with the oldest prediction. Directed tests cover
// the reset state, each packing, the shared FAT12 nibble, the kept FAT32
// nibble, the store boundary and tiny max_cluster values. Random phases then
// switch packing and max_cluster over a table image that carries across
// phases, with bursty input traffic and a stalling result side.
// ----------------------------------------------------------------------------
module tb;
    import fte_pkg::*;

    localparam int          CLK_PERIOD     = 12;
    localparam int          TABLE_BYTES    = FTE_TABLE_SIZE_DEFAULT;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_ITEMS    = 150;
    localparam int          HOT_SPAN       = 40;
    localparam int          SETTLE_CYCLES  = 12;
    // Clearing pass plus ~1300 items at their slowest pacing, taken several
    // times over.
    localparam longint      TIMEOUT_CYCLES = 600000;

    localparam logic        CMD_READ  = 1'b0;
    localparam logic        CMD_WRITE = 1'b1;
    localparam logic [27:0] FULL_MAX  = 28'hFFFFFFF;

    typedef struct {
        logic [ENTRY_W-1:0] value;
        status_t            status;
    } entry_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;   // [27:0] cluster, [55:28] write_value
    logic                   s_tuser;   // [0] command
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;   // [27:0] entry_value, [31:28] zero
    logic [STATUS_W-1:0]    m_tuser;   // [2:0] status

    // Shadow copy of the table and of the registers.
    logic [7:0]             table_image [TABLE_BYTES];
    logic [MODE_W-1:0]      fat_mode_cfg;
    logic [CLUSTER_W-1:0]   max_cluster_cfg;

    entry_result_t          pending_entries [$];
    int unsigned            fail_count;

    fat_table_entry_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Bound the run; a hang in either handshake ends up here.
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("fat_table_entry_engine verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Packing helpers
    // ------------------------------------------------------------------------

    // The high mode bit selects thirty-two-bit packing, so mode 3 is FAT32.
    function automatic pack_t decode_packing(input logic [MODE_W-1:0] mode);
        return mode[1] ? PK_FAT32 : (mode[0] ? PK_FAT16 : PK_FAT12);
    endfunction

    function automatic logic [ENTRY_W-1:0] end_of_chain_mark(input pack_t pk);
        case (pk)
            PK_FAT12: return EOC_FAT12;
            PK_FAT16: return EOC_FAT16;
            default:  return EOC_FAT32;
        endcase
    endfunction

    // Highest cluster whose whole entry still fits in the store.
    function automatic int unsigned last_cluster_in_store(input pack_t pk);
        case (pk)
            PK_FAT12: return ((TABLE_BYTES - 2) * 2) / 3;
            PK_FAT16: return TABLE_BYTES / 2 - 1;
            default:  return TABLE_BYTES / 4 - 1;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Entry access predictor: update the table image and return the result.
    // ------------------------------------------------------------------------
    function automatic entry_result_t predict_entry_access(input logic cmd,
                                                           input logic [27:0] cl,
                                                           input logic [27:0] wv);
        entry_result_t     res;
        pack_t             pk;
        longint unsigned   off;
        int unsigned       nbytes;
        logic [31:0]       word;
        logic [15:0]       half;
        logic [ENTRY_W-1:0] eoc;

        res.value  = '0;
        res.status = ST_RANGE;
        pk         = decode_packing(fat_mode_cfg);

        // Clusters 0 and 1 and anything past max_cluster are rejected.
        if (cl < 2 || cl > max_cluster_cfg)
            return res;

        case (pk)
            PK_FAT12:
            begin
                off    = (64'(cl) * 3) >> 1;
                nbytes = 2;
            end
            PK_FAT16:
            begin
                off    = 64'(cl) << 1;
                nbytes = 2;
            end
            default:
            begin
                off    = 64'(cl) << 2;
                nbytes = 4;
            end
        endcase

        // An entry that does not fit in the store is out of range as well.
        if (off + nbytes > TABLE_BYTES)
            return res;

        if (cmd == CMD_WRITE)
        begin
            case (pk)
                PK_FAT12:
                begin
                    // Keep the nibble that belongs to the neighboring entry.
                    if (cl[0])
                    begin
                        table_image[off]     = {wv[3:0], table_image[off][3:0]};
                        table_image[off + 1] = wv[11:4];
                    end
                    else
                    begin
                        table_image[off]     = wv[7:0];
                        table_image[off + 1] = {table_image[off + 1][7:4], wv[11:8]};
                    end
                end
                PK_FAT16:
                begin
                    table_image[off]     = wv[7:0];
                    table_image[off + 1] = wv[15:8];
                end
                default:
                begin
                    // Keep the reserved top nibble of the 32-bit word.
                    word = {table_image[off + 3][7:4], wv};
                    table_image[off]     = word[7:0];
                    table_image[off + 1] = word[15:8];
                    table_image[off + 2] = word[23:16];
                    table_image[off + 3] = word[31:24];
                end
            endcase
            res.status = ST_WROTE;
            return res;
        end

        eoc = end_of_chain_mark(pk);
        case (pk)
            PK_FAT12:
            begin
                half      = {table_image[off + 1], table_image[off]};
                res.value = ENTRY_W'(cl[0] ? half[15:4] : half[11:0]);
            end
            PK_FAT16:
            begin
                res.value = ENTRY_W'({table_image[off + 1], table_image[off]});
            end
            default:
            begin
                word      = {table_image[off + 3], table_image[off + 2],
                             table_image[off + 1], table_image[off]};
                res.value = word[27:0];
            end
        endcase

        if (res.value >= eoc)
            res.status = ST_EOC;
        else if (res.value > max_cluster_cfg || res.value == 1)
            res.status = ST_BAD;
        else
            res.status = ST_NEXT;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Write one register; only called while nothing is in flight.
    task automatic write_config(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == CFG_FAT_WIDTH_MODE)
            fat_mode_cfg = data[MODE_W-1:0];
        else
            max_cluster_cfg = data;
    endtask

    // Present one item, hold it until accepted, then record its prediction.
    task automatic send_entry_access(input logic cmd, input logic [27:0] cl,
                                     input logic [27:0] wv);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {wv, cl};
        s_tuser  = cmd;
        do
            @(posedge clk);
        while (!s_tready);
        pending_entries.push_back(predict_entry_access(cmd, cl, wv));
    endtask

    task automatic hold_idle(input int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle.
    task automatic wait_drained();
        hold_idle(1);
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall on a pattern that changes at random intervals.
    // ------------------------------------------------------------------------
    initial
    begin : result_ready_pattern
        int unsigned window_left;
        int unsigned stall_style;
        int unsigned run_left;

        m_tready    = 1'b0;
        window_left = 0;
        stall_style = 0;
        run_left    = 0;
        forever
        begin
            @(negedge clk);
            if (window_left == 0)
            begin
                stall_style = $urandom_range(0, 2);
                window_left = $urandom_range(64, 400);
            end
            window_left--;
            case (stall_style)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 3) != 0);
                default:
                begin
                    // Alternate short ready runs with long stalls.
                    if (run_left == 0)
                    begin
                        m_tready = ~m_tready;
                        run_left = m_tready ? $urandom_range(1, 6) : $urandom_range(1, 12);
                    end
                    run_left--;
                end
            endcase
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        entry_result_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_entries.size() == 0)
            begin
                $error("unexpected result item: entry_value %h status %0d",
                       m_tdata[ENTRY_W-1:0], m_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_entries.pop_front();
                if (m_tdata[ENTRY_W-1:0] !== want.value)
                begin
                    $error("entry_value mismatch: expected %h, actual %h",
                           want.value, m_tdata[ENTRY_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[OUT_DATA_W-1:ENTRY_W] !== '0)
                begin
                    $error("tdata pad mismatch: expected %h, actual %h",
                           4'h0, m_tdata[OUT_DATA_W-1:ENTRY_W]);
                    fail_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Reset registers: FAT16, max_cluster 2, empty table.
    task automatic test_reset_state();
        send_entry_access(CMD_READ,  28'd2, 28'd0);
        send_entry_access(CMD_READ,  28'd1, 28'd0);
        send_entry_access(CMD_WRITE, 28'd3, 28'h0000123);
        wait_drained();
    endtask

    // FAT16: truncation of write_value, end of chain, bad marker, store end.
    task automatic test_fat16_entries();
        write_config(CFG_FAT_WIDTH_MODE, CLUSTER_W'(2'd1));
        write_config(CFG_MAX_CLUSTER, FULL_MAX);
        send_entry_access(CMD_WRITE, 28'd2, 28'hFFFFFF8);
        send_entry_access(CMD_READ,  28'd2, 28'd0);
        send_entry_access(CMD_WRITE, 28'd32767, 28'd1);
        send_entry_access(CMD_READ,  28'd32767, 28'hFFFFFFF);
        send_entry_access(CMD_READ,  28'd32768, 28'd0);
        wait_drained();
    endtask

    // FAT12: two neighbors share one byte; each write keeps the other's nibble; also the store end.
    task automatic test_fat12_shared_nibble();
        write_config(CFG_FAT_WIDTH_MODE, CLUSTER_W'(2'd0));
        send_entry_access(CMD_WRITE, 28'd10, 28'h0000ABC);
        send_entry_access(CMD_WRITE, 28'd11, 28'h0000DEF);
        send_entry_access(CMD_READ,  28'd10, 28'd0);
        send_entry_access(CMD_READ,  28'd11, 28'd0);
        send_entry_access(CMD_READ,  28'd43689, 28'd0);
        send_entry_access(CMD_WRITE, 28'd43690, 28'h0000FFF);
        wait_drained();
    endtask

    // FAT32 (through the unused mode 3): the top nibble, set by a FAT16
    // write over the same bytes, survives a FAT32 write.
    task automatic test_fat32_kept_nibble();
        write_config(CFG_FAT_WIDTH_MODE, CLUSTER_W'(2'd1));
        send_entry_access(CMD_WRITE, 28'd7, 28'h000F123);
        wait_drained();
        write_config(CFG_FAT_WIDTH_MODE, CLUSTER_W'(2'd3));
        send_entry_access(CMD_READ,  28'd3, 28'd0);
        send_entry_access(CMD_WRITE, 28'd3, 28'h0ABCDEF);
        send_entry_access(CMD_READ,  28'd3, 28'd0);
        wait_drained();
        write_config(CFG_FAT_WIDTH_MODE, CLUSTER_W'(2'd1));
        send_entry_access(CMD_READ,  28'd7, 28'd0);
        wait_drained();
        write_config(CFG_FAT_WIDTH_MODE, CLUSTER_W'(2'd2));
        send_entry_access(CMD_READ,  28'd16383, 28'd0);
        send_entry_access(CMD_WRITE, 28'd16384, 28'd5);
        wait_drained();
    endtask

    // max_cluster below 2 rejects every cluster; 2 admits exactly one.
    task automatic test_small_max_cluster();
        write_config(CFG_MAX_CLUSTER, 28'd1);
        send_entry_access(CMD_READ, 28'd2, 28'd0);
        wait_drained();
        write_config(CFG_MAX_CLUSTER, 28'd0);
        send_entry_access(CMD_WRITE, 28'd2, 28'd9);
        wait_drained();
        write_config(CFG_MAX_CLUSTER, 28'd2);
        send_entry_access(CMD_READ, 28'd2, 28'd0);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------

    // Mostly a window of neighboring clusters so reads find earlier writes;
    // the rest lands on the store end, around max_cluster, on clusters 0 to 2, or anywhere.
    function automatic logic [27:0] pick_cluster(input int unsigned hot_base);
        int unsigned roll;
        int unsigned store_end;

        roll      = $urandom_range(0, 99);
        store_end = last_cluster_in_store(decode_packing(fat_mode_cfg));
        if (roll < 65)
            return 28'(hot_base + $urandom_range(0, HOT_SPAN - 1));
        if (roll < 77)
            return 28'(store_end - 2 + $urandom_range(0, 4));
        if (roll < 85)
            return 28'(max_cluster_cfg - 1 + $urandom_range(0, 2));
        if (roll < 88)
            return 28'($urandom_range(0, 2));
        return 28'($urandom);
    endfunction

    // Chain links into the hot window, thresholds, markers and noise.
    function automatic logic [27:0] pick_write_value(input int unsigned hot_base);
        int unsigned        roll;
        logic [27:0]        eoc;
        logic [27:0]        picked;

        roll = $urandom_range(0, 99);
        eoc  = end_of_chain_mark(decode_packing(fat_mode_cfg));
        if (roll < 30)
            return 28'($urandom);
        if (roll < 55)
            picked = 28'(hot_base + $urandom_range(0, 2 * HOT_SPAN));
        else if (roll < 72)
            picked = 28'(eoc - 2 + $urandom_range(0, 9));
        else if (roll < 82)
            picked = 28'($urandom_range(0, 1));
        else
            picked = 28'(max_cluster_cfg + $urandom_range(0, 1));
        // Half the time add junk above the entry width; it must be dropped.
        if ($urandom_range(0, 1) == 1)
            picked = picked | (28'($urandom) & ~eoc & ~28'hFFF);
        return picked;
    endfunction

    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned n;
        int unsigned choice;
        int unsigned reach;
        int unsigned hot_base;
        int unsigned burst_left;
        logic [1:0]  mode;
        logic [27:0] max_pick;

        burst_left = 0;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // The first four phases visit every mode and every kind of limit.
            mode   = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            choice = (phase < 4) ? phase : $urandom_range(0, 3);
            case (choice)
                0:       max_pick = 28'($urandom_range(2, 64));
                1:       max_pick = 28'(last_cluster_in_store(decode_packing(mode)));
                2:       max_pick = FULL_MAX;
                default: max_pick = 28'($urandom_range(2, 32'h0FFFFFFF));
            endcase
            write_config(CFG_FAT_WIDTH_MODE, CLUSTER_W'(mode));
            write_config(CFG_MAX_CLUSTER, max_pick);

            reach = last_cluster_in_store(decode_packing(mode));
            if (max_cluster_cfg < reach)
                reach = max_cluster_cfg;
            hot_base = (reach < 2 + HOT_SPAN) ? 2 : $urandom_range(2, reach - HOT_SPAN);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Bursts of back-to-back items separated by idle gaps.
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 3) != 0)
                        hold_idle($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 20);
                end
                burst_left--;
                send_entry_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                                  pick_cluster(hot_base), pick_write_value(hot_base));
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_tests
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_FAT_WIDTH_MODE;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = CMD_READ;
        fail_count      = 0;
        fat_mode_cfg    = MODE_RESET;
        max_cluster_cfg = MAX_CLUSTER_RESET;
        foreach (table_image[i])
            table_image[i] = 8'h00;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The clearing pass holds s_tready low; the first item waits it out.
        test_reset_state();
        test_fat16_entries();
        test_fat12_shared_nibble();
        test_fat32_kept_nibble();
        test_small_max_cluster();
        test_random_traffic();

        wait_drained();
        if (fail_count == 0 && pending_entries.size() == 0)
            $display("fat_table_entry_engine verification clean");
        else
            $display("fat_table_entry_engine verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/fte_pkg.sv
src/fte_datapath.sv
src/fte_ctrl.sv
src/fat_table_entry_engine.sv
test/tb.sv
